### design/mexp_pkg.sv
// Constants for the modular exponentiation block: the prime, the Montgomery
// constants for R = 2^32 and the widths of the request and response buses.
// No dependencies.
package mexp_pkg;

   localparam int REQ_DATA_BITS = 96;
   localparam int RSP_DATA_BITS = 32;

   localparam logic [31:0] PRIME = 32'd1000000007;

   localparam logic [63:0] R_MOD_WIDE  = (64'd1 << 32) % 64'd1000000007;
   localparam logic [63:0] R2_MOD_WIDE = (R_MOD_WIDE * R_MOD_WIDE) % 64'd1000000007;

   localparam logic [29:0] R_MOD  = R_MOD_WIDE[29:0];
   localparam logic [31:0] R2_MOD = R2_MOD_WIDE[31:0];

   // Newton iteration for the inverse of an odd number modulo 2^32, negated.
   function automatic logic [31:0] neg_inverse(input logic [31:0] n);
      logic [31:0] x;
      x = n;
      for (int i = 0; i < 5; i++) begin
         x = x * (32'd2 - n * x);
      end
      return 32'd0 - x;
   endfunction

   localparam logic [31:0] NPRIME = neg_inverse(PRIME);

endpackage

### design/modular_exponentiation.sv
// Modular exponentiation modulo 1000000007 by right-to-left square and multiply.
// Uses mexp_pkg for the prime and the Montgomery constants.
//
// Channel | Direction | Ports                 | Contents
// req     | in        | req_tvalid/tready/data | base, exponent
// rsp     | out       | rsp_tvalid/tready/data | power
//
// One shared 32x32 multiplier does every Montgomery product: first the operand
// product, then its low half times NPRIME, then the low half of that times PRIME,
// and last the add, shift and conditional subtraction of the prime.
// Reset is synchronous and clears the sequencer and the response valid.
// A new request is taken while a result waits; the final step stalls until the
// response register is free.
module modular_exponentiation #(
   parameter int EXP_BITS = 63
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // base [30:0], exponent [93:31], zero fill [95:94]
   input  logic [mexp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // power [29:0], zero fill [31:30]
   output logic [mexp_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import mexp_pkg::*;

   typedef enum logic {ST_IDLE, ST_BUSY} state_type;
   typedef enum logic [1:0] {OP_BASE, OP_ACC, OP_SQ, OP_OUT} op_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [1:0]          phase_ff, phase_in;
   logic [30:0]         base_ff, base_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [29:0]         acc_ff, acc_in;
   logic [29:0]         sq_ff, sq_in;
   logic [63:0]         prod_ff, prod_in;
   logic [60:0]         t_ff, t_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [29:0]         power_ff, power_in;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_full;
   logic [63:0] redc_sum;
   logic [30:0] redc_u;
   logic [29:0] redc_res;

   function automatic op_type next_op(input logic [EXP_BITS-1:0] e);
      if (e == '0) begin
         return OP_OUT;
      end else if (e[0]) begin
         return OP_ACC;
      end else begin
         return OP_SQ;
      end
   endfunction

   always_comb begin
      mul_a = prod_ff[31:0];
      mul_b = PRIME;
      case (phase_ff)
         2'd0: begin
            case (op_ff)
               OP_BASE: begin
                  mul_a = {1'b0, base_ff};
                  mul_b = R2_MOD;
               end
               OP_ACC: begin
                  mul_a = {2'b00, acc_ff};
                  mul_b = {2'b00, sq_ff};
               end
               OP_SQ: begin
                  mul_a = {2'b00, sq_ff};
                  mul_b = {2'b00, sq_ff};
               end
               OP_OUT: begin
                  mul_a = {2'b00, acc_ff};
                  mul_b = 32'd1;
               end
               default: begin
                  mul_a = {2'b00, acc_ff};
                  mul_b = 32'd1;
               end
            endcase
         end
         2'd1: begin
            mul_b = NPRIME;
         end
         default: begin
            mul_b = PRIME;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   assign redc_sum = {3'b000, t_ff} + prod_ff;
   assign redc_u   = redc_sum[62:32];
   assign redc_res = (redc_u >= PRIME[30:0]) ? 30'(redc_u - PRIME[30:0]) : redc_u[29:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff;
      power_in     = power_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               base_in  = req_tdata[30:0];
               exp_in   = req_tdata[31 +: EXP_BITS];
               acc_in   = R_MOD;
               op_in    = OP_BASE;
               phase_in = 2'd0;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (phase_ff != 2'd3) begin
               phase_in = phase_ff + 2'd1;
               prod_in  = mul_full;
               if (phase_ff == 2'd1) begin
                  t_in = prod_ff[60:0];
               end
            end else begin
               phase_in = 2'd0;
               case (op_ff)
                  OP_BASE: begin
                     sq_in = redc_res;
                     op_in = next_op(exp_ff);
                  end
                  OP_ACC: begin
                     acc_in = redc_res;
                     if ((exp_ff >> 1) == '0) begin
                        op_in = OP_OUT;
                     end else begin
                        op_in = OP_SQ;
                     end
                  end
                  OP_SQ: begin
                     sq_in  = redc_res;
                     exp_in = exp_ff >> 1;
                     op_in  = next_op(exp_ff >> 1);
                  end
                  OP_OUT: begin
                     if (!rsp_valid_ff || rsp_tready) begin
                        power_in     = redc_res;
                        rsp_valid_in = 1'b1;
                        state_in     = ST_IDLE;
                     end else begin
                        phase_in = phase_ff;
                     end
                  end
                  default: begin
                     op_in = OP_OUT;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_BASE;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      prod_ff  <= prod_in;
      t_ff     <= t_in;
      power_ff <= power_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, power_ff};

endmodule
